/* sv/khd_pkg.sv */
// ----------------------------------------------------------------------------
// khd_pkg
// Shared types and constants for the key hold detector.
// ----------------------------------------------------------------------------
package khd_pkg;

  localparam int NUM_KEYS  = 3;
  localparam int PIN_W     = 3;
  localparam int IDX_W     = 2;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX       = 8'd255;
  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd10;

  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = 8'd1;

  // lane -> merge
  typedef struct packed {
    logic changed;   // pressed state (inverted pin level) differs from pressed flag
    logic rel_hit;   // a long release if this key is the one that toggles
    logic hold_hit;  // repeat threshold reached after counting
  } lane_info_t;

  // merge -> lane
  typedef struct packed {
    logic sel;       // this key toggles its flag
    logic count_en;  // this key is counted on this poll
    logic clear;     // this key reports in repeat mode, restart count
  } lane_ctrl_t;

endpackage

/* sv/khd_lane.sv */
// ----------------------------------------------------------------------------
// khd_lane
// One key: pressed flag, saturating hold counter and threshold compares.
// ----------------------------------------------------------------------------
module khd_lane
  import khd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             pin_level,
  input  logic             repeat_mode,
  input  logic [CNT_W-1:0] hold_threshold,
  input  lane_ctrl_t       ctrl,
  output lane_info_t       info
);

  logic             flag;
  logic [CNT_W-1:0] count;

  logic             now_pressed;
  logic             flag_next;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] inc;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    now_pressed = ~pin_level;
    flag_next   = ctrl.sel ? now_pressed : flag;
    base        = (ctrl.sel && now_pressed) ? '0 : count;
    inc         = (base == COUNT_MAX) ? COUNT_MAX : base + CNT_W'(1);

    info.changed  = now_pressed != flag;
    info.rel_hit  = !repeat_mode && flag && (count >= hold_threshold);
    info.hold_hit = repeat_mode && flag_next && (inc >= hold_threshold);

    if (ctrl.clear) begin
      count_next = '0;
    end else if (ctrl.count_en && flag_next) begin
      count_next = inc;
    end else begin
      count_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag  <= 1'b0;
      count <= '0;
    end else if (advance) begin
      flag  <= flag_next;
      count <= count_next;
    end
  end

endmodule

/* sv/khd_merge.sv */
// ----------------------------------------------------------------------------
// khd_merge
// Priority picks across lanes: first toggling key, first repeat hit, report.
// ----------------------------------------------------------------------------
module khd_merge
  import khd_pkg::*;
(
  input  lane_info_t             info [NUM_KEYS],
  output lane_ctrl_t             ctrl [NUM_KEYS],
  output logic                   key_valid,
  output logic [IDX_W-1:0]       key_index
);

  logic [NUM_KEYS-1:0] sel;
  logic [NUM_KEYS-1:0] hit;
  logic                rel_report;
  logic                hold_report;
  logic                seen_change;
  logic                seen_hit;
  logic [IDX_W-1:0]    rel_idx;
  logic [IDX_W-1:0]    hold_idx;

  always_comb begin
    seen_change = 1'b0;
    rel_report  = 1'b0;
    rel_idx     = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      sel[k] = info[k].changed && !seen_change;
      if (sel[k] && info[k].rel_hit) begin
        rel_report = 1'b1;
        rel_idx    = IDX_W'(k);
      end
      seen_change = seen_change | info[k].changed;
    end

    seen_hit    = 1'b0;
    hold_report = 1'b0;
    hold_idx    = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      ctrl[k].sel      = sel[k];
      ctrl[k].count_en = !rel_report && !seen_hit;
      hit[k]           = info[k].hold_hit && !rel_report && !seen_hit;
      ctrl[k].clear    = hit[k];
      if (hit[k]) begin
        hold_report = 1'b1;
        hold_idx    = IDX_W'(k);
      end
      seen_hit = seen_hit | hit[k];
    end

    key_valid = rel_report || hold_report;
    key_index = rel_report ? rel_idx : hold_idx;
  end

endmodule

/* sv/key_hold_detector_top.sv */
// ----------------------------------------------------------------------------
// key_hold_detector_top
// Long-press and auto-repeat detector for active-low keys, one lane per key.
// ----------------------------------------------------------------------------
// The report item is registered and reaches the master side in the cycle after the poll is accepted.
// Throughput: 1 poll per cycle while s_tready is high (output register empty or being drained).
// The output register is refilled in the same cycle it is drained.
// Reset (rst, synchronous): flags released, counters zero, repeat_mode 0,
// hold_threshold 10, output empty.
module key_hold_detector_top
  import khd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [2:0] pin_levels
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [0] key_valid, [2:1] key_index
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic             repeat_mode;
  logic [CNT_W-1:0] hold_threshold;
  logic             advance;
  logic             key_valid;
  logic [IDX_W-1:0] key_index;
  logic             out_valid;
  logic [IDX_W:0]   out_data;

  lane_info_t info [NUM_KEYS];
  lane_ctrl_t ctrl [NUM_KEYS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_mode    <= 1'b0;
      hold_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_REPEAT_MODE) begin
        repeat_mode <= cfg_data[0];
      end else if (cfg_index == REG_HOLD_THRESHOLD) begin
        hold_threshold <= cfg_data[CNT_W-1:0];
      end
    end
  end

  assign s_tready = !out_valid || m_tready;
  assign advance  = s_tvalid && s_tready;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    khd_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .advance        (advance),
      .pin_level      (s_tdata[k]),
      .repeat_mode    (repeat_mode),
      .hold_threshold (hold_threshold),
      .ctrl           (ctrl[k]),
      .info           (info[k])
    );
  end

  khd_merge u_merge (
    .info      (info),
    .ctrl      (ctrl),
    .key_valid (key_valid),
    .key_index (key_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {key_index, key_valid};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(TDATA_OUT_W-IDX_W-1){1'b0}}, out_data};

endmodule

/* sv/khd_checker.sv */
// ----------------------------------------------------------------------------
// khd_checker
// Port-level checks on the key hold detector, bound to the top level.
// ----------------------------------------------------------------------------
module khd_checker
  import khd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [TDATA_OUT_W-1:0] m_tdata
);

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("item present right after reset");

  a_item_follows_poll: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted poll gave no item");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !(s_tvalid && s_tready)) |=> !m_tvalid)
    else $error("item repeated after it was taken");

  a_index_zero_no_key: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[2:1] == 2'd0))
    else $error("index nonzero without a report");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:1] != 2'd3 && m_tdata[7:3] == 5'd0))
    else $error("index out of range or padding set");

endmodule

bind key_hold_detector_top khd_checker u_khd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
